### rtl/core/sxe_pkg.sv
`default_nettype none
package sxe_pkg;

    localparam int CHAR_W   = 8;
    localparam int CODE_W   = 3;
    localparam int IDX_W    = 5;
    localparam int NUM_DIGITS = 3;
    localparam int LETTERS  = 26;

    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 8'h7A;

    // Soundex classes: vowel resets the prior code, ignored leaves it alone.
    localparam logic [CODE_W-1:0] CLS_VOWEL   = 3'd0;
    localparam logic [CODE_W-1:0] CLS_IGNORED = 3'd7;

    typedef logic [CODE_W-1:0] code_t;

    localparam code_t LETTER_CLASS [LETTERS] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd7, 3'd0, 3'd2, 3'd2, 3'd4, 3'd5,
        3'd5, 3'd0, 3'd1, 3'd2, 3'd6, 3'd2, 3'd3, 3'd0, 3'd1, 3'd7, 3'd2, 3'd0, 3'd2
    };

    // One classified character, as handed from the front to the back.
    typedef struct packed {
        logic              is_letter;
        code_t             cls;
        logic [CHAR_W-1:0] letter;
        logic              last;
    } entry_t;

    typedef struct packed {
        logic [CHAR_W-1:0] lead_char;
        code_t             digit_one;
        code_t             digit_two;
        code_t             digit_three;
    } result_t;

endpackage
`default_nettype wire

### rtl/core/sxe_front.sv
`default_nettype none
module sxe_front (
    input  wire logic [sxe_pkg::CHAR_W-1:0] char_code,
    input  wire logic                       last_char,
    output sxe_pkg::entry_t                 entry
);

    logic                      upper;
    logic                      lower;
    logic [sxe_pkg::CHAR_W-1:0] offset;
    logic [sxe_pkg::IDX_W-1:0]  idx;

    always_comb begin
        upper  = (char_code >= sxe_pkg::ASCII_UPPER_A) && (char_code <= sxe_pkg::ASCII_UPPER_Z);
        lower  = (char_code >= sxe_pkg::ASCII_LOWER_A) && (char_code <= sxe_pkg::ASCII_LOWER_Z);
        offset = upper ? (char_code - sxe_pkg::ASCII_UPPER_A)
                       : (char_code - sxe_pkg::ASCII_LOWER_A);
        // outside the letter ranges the index is never used; clamp to a legal row
        idx    = (upper || lower) ? offset[sxe_pkg::IDX_W-1:0] : '0;

        entry.is_letter = upper || lower;
        entry.cls       = sxe_pkg::LETTER_CLASS[idx];
        entry.letter    = sxe_pkg::ASCII_UPPER_A + {{(sxe_pkg::CHAR_W-sxe_pkg::IDX_W){1'b0}}, idx};
        entry.last      = last_char;
    end

endmodule
`default_nettype wire

### rtl/core/sxe_queue.sv
`default_nettype none
module sxe_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire sxe_pkg::entry_t push_data,
    output logic                 full,
    input  wire logic            pop,
    output sxe_pkg::entry_t      pop_data,
    output logic                 not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    sxe_pkg::entry_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb begin
        do_push     = push && !full;
        do_pop      = pop && not_empty;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

### rtl/core/sxe_back.sv
`default_nettype none
module sxe_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            q_valid,
    input  wire sxe_pkg::entry_t q_data,
    output logic                 q_pop,
    output logic                 res_valid,
    output sxe_pkg::result_t     res_data,
    input  wire logic            res_ready
);

    logic                        started_reg, started_next;
    logic [sxe_pkg::CHAR_W-1:0]  lead_reg, lead_next;
    sxe_pkg::code_t              prior_reg, prior_next;
    logic [1:0]                  held_reg, held_next;
    sxe_pkg::code_t              digit_reg [sxe_pkg::NUM_DIGITS];
    sxe_pkg::code_t              digit_next [sxe_pkg::NUM_DIGITS];
    logic                        res_valid_reg, res_valid_next;
    sxe_pkg::result_t            res_data_reg, res_data_next;
    logic                        out_free;

    assign out_free  = !res_valid_reg || res_ready;
    // a request that ends a word needs room in the output register
    assign q_pop     = q_valid && (!q_data.last || out_free);
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    always_comb begin
        started_next = started_reg;
        lead_next    = lead_reg;
        prior_next   = prior_reg;
        held_next    = held_reg;
        for (int i = 0; i < sxe_pkg::NUM_DIGITS; i++) begin
            digit_next[i] = digit_reg[i];
        end

        if (q_pop && q_data.is_letter) begin
            if (!started_reg) begin
                started_next = 1'b1;
                lead_next    = q_data.letter;
                prior_next   = (q_data.cls == sxe_pkg::CLS_IGNORED) ? sxe_pkg::CLS_VOWEL
                                                                    : q_data.cls;
            end else if (q_data.cls == sxe_pkg::CLS_IGNORED) begin
                prior_next = prior_reg;
            end else if (q_data.cls == sxe_pkg::CLS_VOWEL) begin
                prior_next = sxe_pkg::CLS_VOWEL;
            end else begin
                if (q_data.cls != prior_reg && held_reg != 2'(sxe_pkg::NUM_DIGITS)) begin
                    for (int i = 0; i < sxe_pkg::NUM_DIGITS; i++) begin
                        if (held_reg == 2'(i)) begin
                            digit_next[i] = q_data.cls;
                        end
                    end
                    held_next = held_reg + 2'd1;
                end
                prior_next = q_data.cls;
            end
        end

        res_data_next  = res_data_reg;
        res_valid_next = res_valid_reg && !res_ready;
        if (q_pop && q_data.last) begin
            res_valid_next             = 1'b1;
            res_data_next.lead_char    = lead_next;
            res_data_next.digit_one    = digit_next[0];
            res_data_next.digit_two    = digit_next[1];
            res_data_next.digit_three  = digit_next[2];
            // drop the word state for the next word
            started_next = 1'b0;
            lead_next    = '0;
            prior_next   = sxe_pkg::CLS_VOWEL;
            held_next    = '0;
            for (int i = 0; i < sxe_pkg::NUM_DIGITS; i++) begin
                digit_next[i] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg   <= 1'b0;
            lead_reg      <= '0;
            prior_reg     <= sxe_pkg::CLS_VOWEL;
            held_reg      <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < sxe_pkg::NUM_DIGITS; i++) begin
                digit_reg[i] <= '0;
            end
        end else begin
            started_reg   <= started_next;
            lead_reg      <= lead_next;
            prior_reg     <= prior_next;
            held_reg      <= held_next;
            res_valid_reg <= res_valid_next;
            for (int i = 0; i < sxe_pkg::NUM_DIGITS; i++) begin
                digit_reg[i] <= digit_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_data_reg <= res_data_next;
    end

endmodule
`default_nettype wire

### rtl/core/soundex_encoder_core.sv
`default_nettype none
// Streaming American Soundex encoder. Feed a word one ASCII character per
// request on s_axis, with tlast on its final character; either case is
// accepted and non-letters are skipped. One result per word comes out on
// m_axis when the tlast character has been taken: the uppercase first letter
// and three Soundex digits, 0 marking padding. A word without letters gives
// letter 0 and digits 000. The block takes one character per cycle while the
// queue has room; the front classifies each character through a 26-entry table,
// a QUEUE_DEPTH entry queue decouples it from the back, which updates the word
// state and holds the result in an output register. A result is loaded into
// m_axis at the same edge that takes its character out of the queue, so the
// tlast character passes the queue slot and then the output register before
// m_axis_tvalid rises. While a result waits on m_axis_tready, the next tlast
// request waits in the queue and the queue fills up behind it.
module soundex_encoder_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  wire logic        s_axis_tlast,   // last_char
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata    // [7:0] lead_char, [10:8] code_digit_one,
                                             // [13:11] code_digit_two,
                                             // [16:14] code_digit_three, [23:17] zero
);

    sxe_pkg::entry_t  front_entry;
    sxe_pkg::entry_t  q_data;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    sxe_pkg::result_t res_data;

    sxe_front u_front (
        .char_code (s_axis_tdata),
        .last_char (s_axis_tlast),
        .entry     (front_entry)
    );

    sxe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_axis_tvalid),
        .push_data (front_entry),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .not_empty (q_valid)
    );

    sxe_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .res_valid (m_axis_tvalid),
        .res_data  (res_data),
        .res_ready (m_axis_tready)
    );

    assign s_axis_tready = !q_full;
    assign m_axis_tdata  = {7'd0, res_data.digit_three, res_data.digit_two,
                            res_data.digit_one, res_data.lead_char};

endmodule
`default_nettype wire

### tb/soundex_checker.sv
module soundex_checker (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_axis_tvalid,
    input  wire logic              s_axis_tready,
    input  wire logic [7:0]        s_axis_tdata,   // [7:0] char_code
    input  wire logic              s_axis_tlast,   // last_char
    input  wire logic              m_axis_tvalid,
    input  wire logic              m_axis_tready,
    input  wire logic [23:0]       m_axis_tdata,   // [7:0] lead_char, [10:8] code_digit_one,
                                                   // [13:11] code_digit_two,
                                                   // [16:14] code_digit_three, [23:17] zero
    output int                     mismatches,
    output int                     codes_outstanding
);

    logic                       word_open;
    logic [sxe_pkg::CHAR_W-1:0] head_letter;
    sxe_pkg::code_t             last_code;
    int unsigned                digit_count;
    sxe_pkg::code_t             digits [sxe_pkg::NUM_DIGITS];
    sxe_pkg::result_t           awaited_codes [$];

    initial begin
        mismatches        = 0;
        codes_outstanding = 0;
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    function automatic sxe_pkg::code_t soundex_class(input logic [sxe_pkg::CHAR_W-1:0] upper_ch);
        case (upper_ch)
            "B", "F", "P", "V":                     return 3'd1;
            "C", "G", "J", "K", "Q", "S", "X", "Z": return 3'd2;
            "D", "T":                               return 3'd3;
            "L":                                    return 3'd4;
            "M", "N":                               return 3'd5;
            "R":                                    return 3'd6;
            "H", "W":                               return sxe_pkg::CLS_IGNORED;
            default:                                return sxe_pkg::CLS_VOWEL;
        endcase
    endfunction

    task automatic clear_word();
        word_open   = 1'b0;
        head_letter = '0;
        last_code   = sxe_pkg::CLS_VOWEL;
        digit_count = 0;
        for (int i = 0; i < sxe_pkg::NUM_DIGITS; i++) digits[i] = '0;
    endtask

    task automatic take_char(input logic [sxe_pkg::CHAR_W-1:0] ch, input logic is_last);
        logic [sxe_pkg::CHAR_W-1:0] up;
        sxe_pkg::code_t             cls;
        sxe_pkg::result_t           res;
        up = ch;
        if (ch >= sxe_pkg::ASCII_LOWER_A && ch <= sxe_pkg::ASCII_LOWER_Z) up = ch - 8'h20;
        if (up >= sxe_pkg::ASCII_UPPER_A && up <= sxe_pkg::ASCII_UPPER_Z) begin
            cls = soundex_class(up);
            if (!word_open) begin
                // the first letter's own code suppresses an equal code right after it
                word_open   = 1'b1;
                head_letter = up;
                last_code   = (cls == sxe_pkg::CLS_IGNORED) ? sxe_pkg::CLS_VOWEL : cls;
            end else if (cls == sxe_pkg::CLS_IGNORED) begin
                // h and w leave the prior code alone
            end else if (cls == sxe_pkg::CLS_VOWEL) begin
                last_code = sxe_pkg::CLS_VOWEL;
            end else begin
                if (cls != last_code && digit_count < sxe_pkg::NUM_DIGITS) begin
                    digits[digit_count] = cls;
                    digit_count++;
                end
                last_code = cls;
            end
        end
        if (is_last) begin
            res.lead_char    = head_letter;
            res.digit_one    = digits[0];
            res.digit_two    = digits[1];
            res.digit_three  = digits[2];
            awaited_codes.push_back(res);
            clear_word();
        end
    endtask

    task automatic check_code(input logic [23:0] got);
        sxe_pkg::result_t want;
        if (awaited_codes.size() == 0) begin
            flag_mismatch("unexpected result", got, 0);
            return;
        end
        want = awaited_codes.pop_front();
        if (got[7:0] !== want.lead_char)
            flag_mismatch("lead_char", got[7:0], want.lead_char);
        if (got[10:8] !== want.digit_one)
            flag_mismatch("code_digit_one", got[10:8], want.digit_one);
        if (got[13:11] !== want.digit_two)
            flag_mismatch("code_digit_two", got[13:11], want.digit_two);
        if (got[16:14] !== want.digit_three)
            flag_mismatch("code_digit_three", got[16:14], want.digit_three);
        if (got[23:17] !== 7'd0)
            flag_mismatch("padding bits", got[23:17], 0);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_word();
            awaited_codes.delete();
        end else begin
            // pop before push: a result never leaves in the cycle its character enters
            if (m_axis_tvalid && m_axis_tready) check_code(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready) take_char(s_axis_tdata, s_axis_tlast);
        end
        codes_outstanding <= awaited_codes.size();
    end

endmodule

### tb/testbench.sv
module testbench;

    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_CHARS = 650;
    localparam int HOLD_AT      = 250;
    localparam int HOLD_CYCLES  = 300;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata  = 8'd0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [23:0] m_axis_tdata;

    int          mismatches;
    int          codes_outstanding;
    int          chars_sent = 0;
    int          idle_cycles = 0;

    always #10 aclk = ~aclk;

    soundex_encoder_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    soundex_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_axis_tvalid     (s_axis_tvalid),
        .s_axis_tready     (s_axis_tready),
        .s_axis_tdata      (s_axis_tdata),
        .s_axis_tlast      (s_axis_tlast),
        .m_axis_tvalid     (m_axis_tvalid),
        .m_axis_tready     (m_axis_tready),
        .m_axis_tdata      (m_axis_tdata),
        .mismatches        (mismatches),
        .codes_outstanding (codes_outstanding)
    );

    // mostly short gaps, a few long ones; none at all in calm stretches
    function automatic int idle_span(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic logic [7:0] pick_char();
        int idx;
        if ($urandom_range(0, 99) < 15) return 8'($urandom_range(0, 255));
        idx = $urandom_range(0, 25);
        if ($urandom_range(0, 1)) return 8'("A" + idx);
        return 8'("a" + idx);
    endfunction

    task automatic offer_char(input logic [7:0] ch, input logic is_last, input bit calm);
        int gap;
        gap = idle_span(calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= is_last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        chars_sent++;
    endtask

    task automatic offer_word(input string w);
        for (int i = 0; i < w.len(); i++) offer_char(w[i], i == w.len() - 1, 1'b0);
    endtask

    // receiver: random back-pressure, one long hold-off to fill the block
    initial begin
        int rx_cycles;
        int stall;
        rx_cycles = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_cycles == HOLD_AT) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            stall = idle_span((rx_cycles / 120) % 4 == 1);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            rx_cycles++;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        int len;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // vowel first letter, h and w between equal codes
        offer_word("Ashcraft");
        // first letter's code suppresses the next equal one
        offer_word("Pfister");
        // word with no letters at all
        offer_char(8'hFF, 1'b1, 1'b0);
        // skipped bytes 8'h00 and 8'h80, lowercase, digits past the third dropped
        offer_char(8'h00, 1'b0, 1'b0);
        offer_char("z", 1'b0, 1'b0);
        offer_char(8'h80, 1'b0, 1'b0);
        offer_word("bcdlmr");

        while (chars_sent < RANDOM_CHARS + 25) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
                offer_char(pick_char(), i == len - 1, (chars_sent / 80) % 4 == 0);
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        @(posedge aclk);
        while (codes_outstanding != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && codes_outstanding == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
